[sv/psw_pkg.sv]
package psw_pkg;

    localparam int REG_WIDTH       = 16;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int PHASE_WIDTH     = 3;

    localparam int DEF_TIMER_WIDTH = 16;
    localparam int DEF_MV_WIDTH    = 16;

    // sequencer phases
    localparam logic [PHASE_WIDTH-1:0] PH_INIT      = 3'd0;
    localparam logic [PHASE_WIDTH-1:0] PH_INIT_DONE = 3'd1;
    localparam logic [PHASE_WIDTH-1:0] PH_ON_WAIT   = 3'd2;
    localparam logic [PHASE_WIDTH-1:0] PH_ON        = 3'd3;
    localparam logic [PHASE_WIDTH-1:0] PH_OFF_WAIT  = 3'd4;
    localparam logic [PHASE_WIDTH-1:0] PH_OFF       = 3'd5;

    // register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_INIT_DELAY  = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ON_DELAY    = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_OFF_DELAY   = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_BLINK       = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_OFF_THRESH  = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DDE_THRESH  = 3'd5;

    // register reset values
    localparam logic [REG_WIDTH-1:0] INIT_DELAY_RST = 16'd100;
    localparam logic [REG_WIDTH-1:0] ON_DELAY_RST   = 16'd100;
    localparam logic [REG_WIDTH-1:0] OFF_DELAY_RST  = 16'd500;
    localparam logic [REG_WIDTH-1:0] BLINK_RST      = 16'd500;
    localparam logic [REG_WIDTH-1:0] OFF_THRESH_RST = 16'd5000;
    localparam logic [REG_WIDTH-1:0] DDE_THRESH_RST = 16'd2000;

    typedef struct packed {
        logic [PHASE_WIDTH-1:0] phase;
        logic                   blink;
        logic                   main_power;
        logic                   ignition_rail;
        logic                   led;
        logic                   hold;
        logic                   standby;
    } psw_flags_t;

    typedef struct packed {
        logic [REG_WIDTH-1:0] init_delay;
        logic [REG_WIDTH-1:0] on_delay;
        logic [REG_WIDTH-1:0] off_delay;
        logic [REG_WIDTH-1:0] blink_interval;
        logic [REG_WIDTH-1:0] off_thresh;
        logic [REG_WIDTH-1:0] dde_thresh;
    } psw_cfg_t;

    localparam psw_flags_t FLAGS_RST = '{
        phase:         PH_INIT,
        blink:         1'b0,
        main_power:    1'b0,
        ignition_rail: 1'b0,
        led:           1'b1,
        hold:          1'b1,
        standby:       1'b1
    };

endpackage

[sv/psw_step.sv]
module psw_step
    import psw_pkg::*;
#(
    parameter int TIMER_WIDTH = DEF_TIMER_WIDTH,
    parameter int MV_WIDTH    = DEF_MV_WIDTH
)
(
    input  psw_flags_t              cur,
    input  logic [TIMER_WIDTH-1:0]  timer_cur,
    input  psw_cfg_t                cfg,
    input  logic                    tick,
    input  logic [MV_WIDTH-1:0]     ignition_mv,
    input  logic [MV_WIDTH-1:0]     kill_mv,
    input  logic [MV_WIDTH-1:0]     dde_switch_mv_in,
    output psw_flags_t              nxt,
    output logic [TIMER_WIDTH-1:0]  timer_next
);

    logic                   kl15;
    logic                   kill;
    logic                   dde;
    logic                   expired;
    logic [TIMER_WIDTH-1:0] timer_dec;

    assign kl15 = REG_WIDTH'(ignition_mv) > cfg.off_thresh;
    assign kill = REG_WIDTH'(kill_mv) > cfg.off_thresh;
    assign dde  = REG_WIDTH'(dde_switch_mv_in) < cfg.dde_thresh;

    // millisecond countdown, holds at zero
    assign timer_dec = (tick && (timer_cur != '0)) ? timer_cur - TIMER_WIDTH'(1) : timer_cur;
    assign expired   = (timer_dec == '0);

    always_comb
    begin
        nxt        = cur;
        timer_next = timer_dec;
        case (cur.phase)
            PH_INIT:
            begin
                if (expired)
                begin
                    nxt.phase = PH_INIT_DONE;
                end
            end
            PH_INIT_DONE:
            begin
                if (kill || !kl15)
                begin
                    nxt.phase      = PH_OFF;
                    nxt.main_power = 1'b0;
                    nxt.hold       = 1'b0;
                    nxt.standby    = 1'b0;
                end
                else
                begin
                    nxt.phase      = PH_ON_WAIT;
                    nxt.main_power = 1'b1;
                    timer_next     = TIMER_WIDTH'(cfg.on_delay);
                end
            end
            PH_ON_WAIT:
            begin
                if (kill)
                begin
                    nxt.phase      = PH_OFF;
                    nxt.main_power = 1'b0;
                    nxt.hold       = 1'b0;
                    nxt.standby    = 1'b0;
                end
                else if (expired)
                begin
                    nxt.phase         = PH_ON;
                    nxt.ignition_rail = 1'b1;
                end
            end
            PH_ON:
            begin
                if (kill || !kl15)
                begin
                    nxt.phase         = PH_OFF_WAIT;
                    nxt.led           = 1'b0;
                    nxt.ignition_rail = 1'b0;
                    timer_next        = TIMER_WIDTH'(cfg.off_delay);
                end
            end
            PH_OFF_WAIT:
            begin
                // leave as soon as the dde switch is released or the off delay runs out
                if (!dde || expired)
                begin
                    nxt.phase      = PH_OFF;
                    nxt.main_power = 1'b0;
                    nxt.hold       = 1'b0;
                    nxt.standby    = 1'b0;
                end
            end
            PH_OFF:
            begin
                if (expired)
                begin
                    nxt.led     = cur.blink;
                    nxt.standby = cur.blink;
                    nxt.hold    = 1'b0;
                    nxt.blink   = ~cur.blink;
                    timer_next  = TIMER_WIDTH'(cfg.blink_interval);
                end
            end
            default:
            begin
                // unused phase codes fall into off
                nxt.phase      = PH_OFF;
                nxt.main_power = 1'b0;
                nxt.hold       = 1'b0;
                nxt.standby    = 1'b0;
            end
        endcase
    end

endmodule

[sv/power_switch_sequencer_core.sv]
// power switch sequencer: one result beat per accepted poll beat
// an accepted poll's result is registered and shown on the outputs in the cycle after it is taken
// throughput: 1 poll per cycle unless a result beat is stalled, set by the single state register update per poll
// a stalled result holds the input side; a new poll is taken while the result drains
// reset: phase init, timer loaded with the init delay reset value, led, hold and
// standby high, registers at their reset values, no result pending
module power_switch_sequencer_core
    import psw_pkg::*;
#(
    parameter int TIMER_WIDTH = DEF_TIMER_WIDTH,
    parameter int MV_WIDTH    = DEF_MV_WIDTH
)
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [REG_WIDTH-1:0]        cfg_data,

    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        tick,
    input  logic [MV_WIDTH-1:0]         ignition_mv,
    input  logic [MV_WIDTH-1:0]         kill_mv,
    input  logic [MV_WIDTH-1:0]         dde_switch_mv_in,

    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [PHASE_WIDTH-1:0]      phase,
    output logic                        main_power,
    output logic                        ignition_rail,
    output logic                        led,
    output logic                        kill_pullup,
    output logic                        power_hold,
    output logic                        can_standby_n,
    output logic                        run_active
);

    psw_cfg_t               cfg_reg;
    psw_flags_t             flags_reg;
    psw_flags_t             flags_next;
    logic [TIMER_WIDTH-1:0] timer_reg;
    logic [TIMER_WIDTH-1:0] timer_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   in_accept;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.init_delay     <= INIT_DELAY_RST;
            cfg_reg.on_delay       <= ON_DELAY_RST;
            cfg_reg.off_delay      <= OFF_DELAY_RST;
            cfg_reg.blink_interval <= BLINK_RST;
            cfg_reg.off_thresh     <= OFF_THRESH_RST;
            cfg_reg.dde_thresh     <= DDE_THRESH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_INIT_DELAY: cfg_reg.init_delay     <= cfg_data;
                CFG_ON_DELAY:   cfg_reg.on_delay       <= cfg_data;
                CFG_OFF_DELAY:  cfg_reg.off_delay      <= cfg_data;
                CFG_BLINK:      cfg_reg.blink_interval <= cfg_data;
                CFG_OFF_THRESH: cfg_reg.off_thresh     <= cfg_data;
                CFG_DDE_THRESH: cfg_reg.dde_thresh     <= cfg_data;
                default:        ;
            endcase
        end
    end

    psw_step #(
        .TIMER_WIDTH (TIMER_WIDTH),
        .MV_WIDTH    (MV_WIDTH)
    ) u_step (
        .cur              (flags_reg),
        .timer_cur        (timer_reg),
        .cfg              (cfg_reg),
        .tick             (tick),
        .ignition_mv      (ignition_mv),
        .kill_mv          (kill_mv),
        .dde_switch_mv_in (dde_switch_mv_in),
        .nxt              (flags_next),
        .timer_next       (timer_next)
    );

    // the state registers double as the result register: they only move
    // when the pending result beat is gone or leaves this cycle
    assign in_stall       = out_valid_reg && out_stall;
    assign in_accept      = in_valid && !in_stall;
    assign out_valid_next = in_accept || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg     <= FLAGS_RST;
            timer_reg     <= TIMER_WIDTH'(INIT_DELAY_RST);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                flags_reg <= flags_next;
                timer_reg <= timer_next;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign phase         = flags_reg.phase;
    assign main_power    = flags_reg.main_power;
    assign ignition_rail = flags_reg.ignition_rail;
    assign led           = flags_reg.led;
    assign kill_pullup   = 1'b1;
    assign power_hold    = flags_reg.hold;
    assign can_standby_n = flags_reg.standby;
    assign run_active    = (flags_reg.phase == PH_ON);

    a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(flags_reg) && $stable(timer_reg))
        else $error("state moved while result beat stalled");

    a_off_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        (flags_reg.phase == PH_OFF) |=> (flags_reg.phase == PH_OFF))
        else $error("left off phase");

    a_off_outputs: assert property (@(posedge clk) disable iff (!rst_n)
        (flags_reg.phase == PH_OFF) |-> (!flags_reg.main_power && !flags_reg.hold))
        else $error("main power or hold active in off phase");

    a_rail_only_on: assert property (@(posedge clk) disable iff (!rst_n)
        flags_reg.ignition_rail |-> (flags_reg.phase == PH_ON))
        else $error("ignition rail active outside on phase");

endmodule
